// ===== rtl/srank_pkg.sv =====
// Shared types, codes and helpers for the spatial rank accumulator.
// No dependencies; the top level, front, divider and back end import this package.
`default_nettype none
package srank_pkg;

    // input function codes
    localparam logic [2:0] FUNC_LOAD_REF   = 3'd0;
    localparam logic [2:0] FUNC_SAMPLE     = 3'd1;
    localparam logic [2:0] FUNC_READ       = 3'd2;
    localparam logic [2:0] FUNC_LOAD_PRIOR = 3'd3;
    localparam logic [2:0] FUNC_CLEAR      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd0;
    localparam logic [1:0] CFG_TOTAL_COUNT   = 2'd1;
    localparam logic [1:0] CFG_PRIOR_COUNT   = 2'd2;

    localparam int VALUE_W = 24;
    localparam int DIFF_W  = 25;
    localparam int RANK_W  = 32;
    localparam int SSUM_W  = 56;
    localparam int NUM_W   = 59;
    localparam int DEN_W   = 48;
    localparam int QUO_W   = 33;

    // classified command, front to back
    typedef enum logic [2:0] {
        OP_REF,
        OP_SAMP,
        OP_READ,
        OP_READ_ZERO,
        OP_PRIOR,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [5:0]                 idx;
        logic                       last;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAMP_D,
        S_SAMP_SQ,
        S_SAMP_ACC,
        S_SQRT,
        S_DEN,
        S_FIN_RD,
        S_FIN_NUM,
        S_PRI_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_READ,
        S_CLR
    } t_bstate;

    // a + (neg ? -q : q), saturated to signed 32 bits; ovf means q >= 2^33
    function automatic logic signed [RANK_W-1:0] sat_add(
        input logic signed [RANK_W-1:0] a,
        input logic                     neg,
        input logic [QUO_W-1:0]         q,
        input logic                     ovf
    );
        logic signed [34:0] qs;
        logic signed [34:0] s;
        qs = $signed({2'b00, q});
        if (neg) begin
            qs = -qs;
        end
        s = $signed({{3{a[RANK_W-1]}}, a}) + qs;
        if (ovf) begin
            sat_add = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (s > 35'sd2147483647) begin
            sat_add = 32'sh7FFF_FFFF;
        end else if (s < -35'sd2147483648) begin
            sat_add = 32'sh8000_0000;
        end else begin
            sat_add = s[RANK_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/spatial_rank_accumulator_top.sv =====
// Top level of the spatial rank accumulator: config registers, front, queues, back.
// Depends on srank_pkg, srank_front, srank_fifo, srank_back.
//
//  channel   handshake          payload
//  input     push / full        i_func, i_index, i_value
//  result    empty / pop        o_rank_value
//  config    i_cfg_we           i_cfg_index, i_cfg_data
//
// Sample element: difference, square, accumulate; the last element adds a
// bit-serial square root and a denominator step, then per entry a read, numerator
// and one-bit-per-cycle divide. Prior load: multiply, then divide; read: RAM read,
// then push; clear: zero sweep of all MAX_DIM entries, also run after reset with
// full held high. A four-entry command queue lets the input side run ahead of
// the back end; a two-entry result queue holds reads while pop is low.
`default_nettype none
module spatial_rank_accumulator_top #(
    parameter int MAX_DIM = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_func,
    input  wire logic [5:0]  i_index,
    input  wire logic signed [23:0] i_value,
    output logic             empty,
    input  wire logic        pop,
    output logic signed [31:0] o_rank_value,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import srank_pkg::*;

    localparam int LCAP = (MAX_DIM < 127) ? MAX_DIM : 127;

    logic [6:0]  r_vector_length;
    logic [15:0] r_total_count, r_prior_count;
    logic [6:0]  eff_len;
    logic [15:0] eff_total;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= 7'd64;
            r_total_count   <= 16'd1;
            r_prior_count   <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VECTOR_LENGTH: r_vector_length <= i_cfg_data[6:0];
                CFG_TOTAL_COUNT:   r_total_count   <= i_cfg_data;
                CFG_PRIOR_COUNT:   r_prior_count   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign eff_len = (r_vector_length == '0) ? 7'd1 :
                     (32'(r_vector_length) > LCAP) ? 7'(LCAP) : r_vector_length;
    assign eff_total = (r_total_count == '0) ? 16'd1 : r_total_count;

    logic q_push, q_full, q_empty, q_pop, init;
    t_cmd q_in, q_out;
    logic [$bits(t_cmd)-1:0] q_out_bits;
    logic res_push, res_full;
    logic [RANK_W-1:0] res_data, res_out;

    srank_front #(.MAX_DIM(MAX_DIM)) u_front (
        .push(push), .i_func(i_func), .i_index(i_index), .i_value(i_value),
        .i_len(eff_len), .i_init(init), .i_q_full(q_full),
        .full(full), .o_q_push(q_push), .o_q_cmd(q_in)
    );

    srank_fifo #(.W($bits(t_cmd)), .DEPTH(4)) u_cmdq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(q_push), .i_data(q_in),
        .i_pop(q_pop), .o_data(q_out_bits), .o_full(q_full), .o_empty(q_empty)
    );
    assign q_out = t_cmd'(q_out_bits);

    srank_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_len(eff_len), .i_total(eff_total),
        .i_prior(r_prior_count), .i_cmd(q_out), .i_cmd_empty(q_empty),
        .o_cmd_pop(q_pop), .i_res_full(res_full), .o_res_push(res_push),
        .o_res_data(res_data), .o_init(init)
    );

    srank_fifo #(.W(RANK_W), .DEPTH(2)) u_resq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(res_push), .i_data(res_data),
        .i_pop(pop), .o_data(res_out), .o_full(res_full), .o_empty(empty)
    );
    assign o_rank_value = $signed(res_out);
endmodule
`default_nettype wire

// ===== rtl/srank_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module srank_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [W-1:0]       o_rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/srank_fifo.sv =====
// Small register queue used between front and back and for results.
// No package dependencies.
`default_nettype none
module srank_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/srank_front.sv =====
// Front end: accepts input beats, drops ignored ones, classifies the rest.
// Depends on srank_pkg.
`default_nettype none
module srank_front #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                             push,
    input  wire logic [2:0]                       i_func,
    input  wire logic [5:0]                       i_index,
    input  wire logic signed [srank_pkg::VALUE_W-1:0] i_value,
    input  wire logic [6:0]                       i_len,
    input  wire logic                             i_init,
    input  wire logic                             i_q_full,
    output logic                                  full,
    output logic                                  o_q_push,
    output srank_pkg::t_cmd                       o_q_cmd
);
    import srank_pkg::*;

    logic in_range, keep;

    assign full     = i_q_full || i_init;
    assign in_range = ({1'b0, i_index} < i_len);

    // classify and decide whether the beat reaches the back end
    always_comb begin
        o_q_cmd.idx   = i_index;
        o_q_cmd.value = i_value;
        o_q_cmd.last  = ({1'b0, i_index} == (i_len - 7'd1));
        o_q_cmd.op    = OP_CLEAR;
        keep          = 1'b0;
        unique case (i_func)
            FUNC_LOAD_REF: begin
                o_q_cmd.op = OP_REF;
                keep       = in_range;
            end
            FUNC_SAMPLE: begin
                o_q_cmd.op = OP_SAMP;
                keep       = in_range;
            end
            FUNC_READ: begin
                o_q_cmd.op = (32'(i_index) >= MAX_DIM) ? OP_READ_ZERO : OP_READ;
                keep       = 1'b1;
            end
            FUNC_LOAD_PRIOR: begin
                o_q_cmd.op = OP_PRIOR;
                keep       = in_range;
            end
            FUNC_CLEAR: begin
                o_q_cmd.op = OP_CLEAR;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_q_push = push && !full && keep;
endmodule
`default_nettype wire

// ===== rtl/srank_div.sv =====
// Restoring divider, one quotient bit per cycle, overflow flagged at 2^33.
// Depends on srank_pkg.
`default_nettype none
module srank_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [srank_pkg::NUM_W-1:0]   i_num,
    input  wire logic [srank_pkg::DEN_W-1:0]   i_den,
    output logic                               o_done,
    output logic [srank_pkg::QUO_W-1:0]        o_quo,
    output logic                               o_ovf
);
    import srank_pkg::*;

    logic             r_busy, r_done, r_ovf;
    logic [5:0]       r_cnt;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [QUO_W-1:0] r_low;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign o_done = r_done;
    assign o_quo  = r_low;
    assign o_ovf  = r_ovf;
    assign trial  = {r_rem, r_low[QUO_W-1]};
    assign fits   = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // quotient at or above 2^33 saturates any later sum
                if ({22'b0, i_num} >= {i_den, 33'b0}) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: remainder and shifting numerator/quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= ({22'b0, i_num} >= {i_den, 33'b0});
            r_rem <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_low <= i_num[QUO_W-1:0];
            r_den <= i_den;
            r_cnt <= 6'(QUO_W);
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_low <= {r_low[QUO_W-2:0], fits};
            r_cnt <= r_cnt - 6'd1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/srank_back.sv =====
// Back end: executes classified commands on the stores and accumulator.
// Depends on srank_pkg, srank_ram and srank_div.
`default_nettype none
module srank_back #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [6:0]           i_len,
    input  wire logic [15:0]          i_total,
    input  wire logic [15:0]          i_prior,
    input  wire srank_pkg::t_cmd      i_cmd,
    input  wire logic                 i_cmd_empty,
    output logic                      o_cmd_pop,
    input  wire logic                 i_res_full,
    output logic                      o_res_push,
    output logic [srank_pkg::RANK_W-1:0] o_res_data,
    output logic                      o_init
);
    import srank_pkg::*;

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    t_bstate r_state, n_state;
    logic    r_init, n_init;
    t_cmd    r_cmd, n_cmd;
    logic signed [DIFF_W-1:0] r_d, n_d;
    logic [49:0]       r_sq, n_sq;
    logic [SSUM_W-1:0] r_ss, n_ss;
    logic [63:0]       r_x, n_x, r_r, n_r, r_bit, n_bit;
    logic [4:0]        r_scnt, n_scnt;
    logic [DEN_W-1:0]  r_den, n_den, r_dden, n_dden;
    logic [NUM_W-1:0]  r_num, n_num;
    logic              r_neg, n_neg;
    logic [6:0]        r_i, n_i;
    logic [AW-1:0]     r_clr, n_clr;

    // address mapping of 6-bit indexes and the entry counter
    logic [AW+5:0] head_ext, cmd_ext;
    logic [AW+6:0] i_ext;
    logic [AW-1:0] head_addr, cmd_addr, i_addr;
    assign head_ext  = {{AW{1'b0}}, i_cmd.idx};
    assign cmd_ext   = {{AW{1'b0}}, r_cmd.idx};
    assign i_ext     = {{AW{1'b0}}, r_i};
    assign head_addr = head_ext[AW-1:0];
    assign cmd_addr  = cmd_ext[AW-1:0];
    assign i_addr    = i_ext[AW-1:0];

    // memories
    logic                     ref_we, dif_we, acc_we;
    logic [AW-1:0]            ref_waddr, acc_waddr, acc_raddr;
    logic [VALUE_W-1:0]       ref_wdata, ref_rdata;
    logic [DIFF_W-1:0]        dif_wdata, dif_rdata;
    logic [RANK_W-1:0]        acc_wdata, acc_rdata;

    assign acc_raddr = (r_state == S_IDLE) ? head_addr : i_addr;

    srank_ram #(.W(VALUE_W), .DEPTH(MAX_DIM)) u_ref (
        .i_clk(i_clk), .i_we(ref_we), .i_waddr(ref_waddr), .i_wdata(ref_wdata),
        .i_raddr(head_addr), .o_rdata(ref_rdata)
    );
    srank_ram #(.W(DIFF_W), .DEPTH(MAX_DIM)) u_dif (
        .i_clk(i_clk), .i_we(dif_we), .i_waddr(cmd_addr), .i_wdata(dif_wdata),
        .i_raddr(i_addr), .o_rdata(dif_rdata)
    );
    srank_ram #(.W(RANK_W), .DEPTH(MAX_DIM)) u_acc (
        .i_clk(i_clk), .i_we(acc_we), .i_waddr(acc_waddr), .i_wdata(acc_wdata),
        .i_raddr(acc_raddr), .o_rdata(acc_rdata)
    );

    // shared divider
    logic             div_start, div_done, div_ovf;
    logic [QUO_W-1:0] div_quo;
    srank_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(r_num),
        .i_den(r_dden), .o_done(div_done), .o_quo(div_quo), .o_ovf(div_ovf)
    );

    assign o_init = r_init;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_init  <= 1'b1;
            r_ss    <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_ss    <= n_ss;
            r_clr   <= n_clr;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_d    <= n_d;
        r_sq   <= n_sq;
        r_x    <= n_x;
        r_r    <= n_r;
        r_bit  <= n_bit;
        r_scnt <= n_scnt;
        r_den  <= n_den;
        r_dden <= n_dden;
        r_num  <= n_num;
        r_neg  <= n_neg;
        r_i    <= n_i;
    end

    // next state and outputs
    always_comb begin
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        dmag;
        logic [56:0]              ssum;
        logic [63:0]              trial;
        logic [VALUE_W-1:0]       vmag;
        logic [31:0]              magp;
        logic [6:0]               i_next;

        n_state = r_state;  n_init = r_init;  n_cmd = r_cmd;  n_d = r_d;
        n_sq = r_sq;  n_ss = r_ss;  n_x = r_x;  n_r = r_r;  n_bit = r_bit;
        n_scnt = r_scnt;  n_den = r_den;  n_dden = r_dden;  n_num = r_num;
        n_neg = r_neg;  n_i = r_i;  n_clr = r_clr;

        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res_data = acc_rdata;
        ref_we = 1'b0;  ref_waddr = head_addr;  ref_wdata = i_cmd.value;
        dif_we = 1'b0;  dif_wdata = '0;
        acc_we = 1'b0;  acc_waddr = i_addr;  acc_wdata = '0;
        div_start = 1'b0;

        d      = $signed(dif_rdata);
        dmag   = d[DIFF_W-1] ? DIFF_W'(-d) : d;
        ssum   = {1'b0, r_ss} + {7'b0, r_sq};
        trial  = r_r + r_bit;
        vmag   = r_cmd.value[VALUE_W-1] ? VALUE_W'(-r_cmd.value) : r_cmd.value;
        magp   = {vmag, 8'b0};
        i_next = r_i + 7'd1;

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.op)
                        OP_REF: begin
                            o_cmd_pop = 1'b1;
                            ref_we    = 1'b1;
                        end
                        OP_SAMP: begin
                            o_cmd_pop = 1'b1;
                            n_cmd     = i_cmd;
                            n_state   = S_SAMP_D;
                        end
                        OP_READ: begin
                            if (!i_res_full) begin
                                o_cmd_pop = 1'b1;
                                n_state   = S_READ;
                            end
                        end
                        OP_READ_ZERO: begin
                            if (!i_res_full) begin
                                o_cmd_pop  = 1'b1;
                                o_res_push = 1'b1;
                                o_res_data = '0;
                            end
                        end
                        OP_PRIOR: begin
                            o_cmd_pop = 1'b1;
                            n_cmd     = i_cmd;
                            n_state   = S_PRI_MUL;
                        end
                        OP_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            n_ss      = '0;
                            n_clr     = '0;
                            n_state   = S_CLR;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            // difference against the stored reference
            S_SAMP_D: begin
                n_d = $signed({ref_rdata[VALUE_W-1], ref_rdata})
                    - $signed({r_cmd.value[VALUE_W-1], r_cmd.value});
                dif_we    = 1'b1;
                dif_wdata = n_d;
                n_state   = S_SAMP_SQ;
            end
            S_SAMP_SQ: begin
                n_sq    = 50'((r_d[DIFF_W-1] ? DIFF_W'(-r_d) : r_d)
                              * (r_d[DIFF_W-1] ? DIFF_W'(-r_d) : r_d));
                n_state = S_SAMP_ACC;
            end
            // saturating square sum; last element starts the norm
            S_SAMP_ACC: begin
                n_ss = ssum[56] ? {SSUM_W{1'b1}} : ssum[SSUM_W-1:0];
                if (r_cmd.last) begin
                    n_x     = {n_ss, 8'b0};
                    n_r     = '0;
                    n_bit   = 64'h4000_0000_0000_0000;
                    n_scnt  = '0;
                    n_ss    = '0;
                    n_state = S_SQRT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // integer square root, one result bit per cycle
            S_SQRT: begin
                if (r_x >= trial) begin
                    n_x = r_x - trial;
                    n_r = (r_r >> 1) + r_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_bit  = r_bit >> 2;
                n_scnt = r_scnt + 5'd1;
                if (r_scnt == 5'd31) begin
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                n_den = DEN_W'(r_r[31:0] * i_total);
                n_i   = '0;
                n_state = (r_r == '0) ? S_IDLE : S_FIN_RD;
            end
            S_FIN_RD: begin
                n_state = S_FIN_NUM;
            end
            S_FIN_NUM: begin
                n_num   = {dmag, 34'b0} + NUM_W'(r_den >> 1);
                n_dden  = r_den;
                n_neg   = d[DIFF_W-1];
                n_state = S_DIV_GO;
            end
            S_PRI_MUL: begin
                n_num   = NUM_W'(magp * i_prior) + NUM_W'(i_total >> 1);
                n_dden  = DEN_W'(i_total);
                n_neg   = r_cmd.value[VALUE_W-1];
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    acc_we = 1'b1;
                    if (r_cmd.op == OP_PRIOR) begin
                        acc_waddr = cmd_addr;
                        acc_wdata = sat_add('0, r_neg, div_quo, div_ovf);
                        n_state   = S_IDLE;
                    end else begin
                        acc_wdata = sat_add($signed(acc_rdata), r_neg, div_quo, div_ovf);
                        n_i       = i_next;
                        n_state   = (i_next == i_len) ? S_IDLE : S_FIN_RD;
                    end
                end
            end
            S_READ: begin
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            // zero sweep over the accumulator
            S_CLR: begin
                acc_we    = 1'b1;
                acc_waddr = r_clr;
                if (r_clr == AW'(MAX_DIM - 1)) begin
                    n_init  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/srank_checker.sv =====
// Port-level checks for the spatial rank accumulator, bound to the top level.
// Depends on spatial_rank_accumulator_top.
`default_nettype none
module srank_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_rank_value
);
    // clearing pass follows reset, so no beat is taken right after it
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low right after reset");

    // no result may appear out of reset
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // a waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rank_value)))
        else $error("waiting result changed or vanished");
endmodule

bind spatial_rank_accumulator_top srank_checker u_srank_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full), .empty(empty),
    .pop(pop), .o_rank_value(o_rank_value)
);
`default_nettype wire

// ===== tb/sv/tb_spatial_rank_accumulator_top.sv =====
// Self-checking testbench for spatial_rank_accumulator_top: reference and sample
// vectors, prior loads, clears and reads checked against an in-bench rank predictor.
// Depends on srank_pkg and the rtl top level only.
`timescale 1ns / 100ps
module tb_spatial_rank_accumulator_top;
    import srank_pkg::*;

    localparam int LANES = 64;
    localparam longint unsigned SSUM_MAX = (64'd1 << 56) - 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_func;
    logic [5:0]  i_index;
    logic signed [23:0] i_value;
    logic        empty;
    logic        pop;
    logic signed [31:0] o_rank_value;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    spatial_rank_accumulator_top #(.MAX_DIM(LANES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full),
        .i_func(i_func), .i_index(i_index), .i_value(i_value),
        .empty(empty), .pop(pop), .o_rank_value(o_rank_value),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [6:0]  len_reg;
    logic [15:0] total_reg;
    logic [15:0] prior_reg;
    logic signed [23:0] ref_mem [LANES];
    logic signed [24:0] diff_mem [LANES];
    logic signed [31:0] rank_mem [LANES];
    bit          ref_ok [LANES];
    bit          diff_ok [LANES];
    longint unsigned sq_sum;

    logic signed [31:0] rank_expect [$];
    int err_count;
    int beats_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------- predictor ----------------
    function automatic int lane_count();
        if (len_reg == 0) return 1;
        if (len_reg > LANES) return LANES;
        return int'(len_reg);
    endfunction

    function automatic longint unsigned divisor_n();
        return (total_reg == 0) ? 64'd1 : longint'(total_reg);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // norm, then add rounded diff*2^34/(norm*N) to every lane in use
    task automatic close_sample(input int n);
        longint unsigned r;
        longint unsigned den;
        longint unsigned mag;
        longint q;
        longint d;
        r = root_floor(sq_sum << 8);
        sq_sum = 0;
        if (r == 0) return;
        den = r * divisor_n();
        for (int i = 0; i < n; i++) begin
            d = diff_mem[i];
            mag = (d < 0) ? -d : d;
            q = ((mag << 34) + den / 2) / den;
            if (d < 0) q = -q;
            rank_mem[i] = clamp32(longint'(rank_mem[i]) + q);
        end
    endtask

    task automatic predict_beat(input logic [2:0] f, input logic [5:0] idx,
                                input logic signed [23:0] val);
        int n;
        longint v;
        longint d;
        longint unsigned mag;
        longint q;
        n = lane_count();
        v = val;
        if (f == FUNC_READ) begin
            rank_expect.insert(rank_expect.size(), rank_mem[idx]);
        end else if (f == FUNC_CLEAR) begin
            foreach (rank_mem[i]) rank_mem[i] = '0;
            sq_sum = 0;
        end else if (f <= FUNC_CLEAR && int'(idx) < n) begin
            case (f)
                FUNC_LOAD_REF: begin
                    ref_mem[idx] = val;
                    ref_ok[idx] = 1'b1;
                end
                FUNC_SAMPLE: begin
                    d = longint'(ref_mem[idx]) - v;
                    mag = (d < 0) ? -d : d;
                    diff_mem[idx] = d[24:0];
                    diff_ok[idx] = 1'b1;
                    sq_sum = (sq_sum + mag * mag > SSUM_MAX) ? SSUM_MAX : sq_sum + mag * mag;
                    if (int'(idx) == n - 1) close_sample(n);
                end
                default: begin
                    mag = ((v < 0) ? -v : v) << 8;
                    q = (mag * prior_reg + divisor_n() / 2) / divisor_n();
                    if (v < 0) q = -q;
                    rank_mem[idx] = clamp32(q);
                end
            endcase
        end
    endtask

    // ---------------- driving ----------------
    function automatic logic signed [23:0] rand_value();
        case ($urandom_range(7))
            0: return 24'sh7F_FFFF;
            1: return 24'sh80_0000;
            2: return $signed(24'($urandom_range(511))) - 24'sd256;
            default: return 24'($urandom());
        endcase
    endfunction

    // one input beat, predicted at the edge that accepted it; push then drops at random
    task automatic send(input logic [2:0] f, input logic [5:0] idx,
                        input logic signed [23:0] val);
        push <= 1'b1;
        i_func <= f;
        i_index <= idx;
        i_value <= val;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_beat(f, idx, val);
        beats_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // keep samples legal: reference written first, no unwritten difference used
    task automatic offer(input logic [2:0] f, input logic [5:0] idx,
                         input logic signed [23:0] val);
        int n;
        n = lane_count();
        if (f == FUNC_SAMPLE && int'(idx) < n) begin
            if (int'(idx) == n - 1) begin
                for (int j = 0; j < n - 1; j++) begin
                    if (!diff_ok[j]) begin
                        idx = 6'(j);
                        break;
                    end
                end
            end
            if (!ref_ok[idx]) send(FUNC_LOAD_REF, idx, rand_value());
        end
        send(f, idx, val);
    endtask

    task automatic sample_vector(input bit match_ref);
        int n;
        n = lane_count();
        for (int i = 0; i < n; i++) begin
            if (!ref_ok[i]) offer(FUNC_LOAD_REF, 6'(i), rand_value());
            offer(FUNC_SAMPLE, 6'(i), match_ref ? ref_mem[i] : rand_value());
        end
    endtask

    // flush with a read, wait for every result, then let the back end settle
    task automatic drain();
        send(FUNC_READ, 6'($urandom_range(63)), rand_value());
        push <= 1'b0;
        while (rank_expect.size() != 0) @(posedge i_clk);
        repeat (40 * lane_count() + 200) @(posedge i_clk);
    endtask

    // write enable drops between writes so back-to-back writes never overlap
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_VECTOR_LENGTH: len_reg = data[6:0];
            CFG_TOTAL_COUNT:   total_reg = data;
            default:           prior_reg = data;
        endcase
    endtask

    // ---------------- result side ----------------
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            pop <= 1'b0;
            hold_req = hold_req - 1;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (rank_expect.size() == 0) begin
                flag_error($sformatf("unexpected rank beat %0d", o_rank_value));
            end else begin
                if (o_rank_value !== rank_expect[0])
                    flag_error($sformatf("rank_value got %0d want %0d",
                                         o_rank_value, rank_expect[0]));
                void'(rank_expect.pop_front());
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        logic signed [23:0] ext [4];
        ext = '{24'sh7F_FFFF, 24'sh80_0000, 24'sh00_0000, 24'sh00_0001};
        cfg_write(CFG_VECTOR_LENGTH, 16'd4);
        cfg_write(CFG_TOTAL_COUNT, 16'd1);
        cfg_write(CFG_PRIOR_COUNT, 16'd0);
        for (int i = 0; i < 4; i++) send(FUNC_LOAD_REF, 6'(i), ext[i]);
        // sample equal to reference: zero norm, nothing added
        for (int i = 0; i < 4; i++) send(FUNC_SAMPLE, 6'(i), ext[i]);
        send(FUNC_READ, 6'd0, 24'sd0);
        // opposite extremes, twice: both passes add to the same lanes
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < 4; i++) send(FUNC_SAMPLE, 6'(i), ext[3 - i]);
        for (int i = 0; i < 4; i++) send(FUNC_READ, 6'(i), 24'sd0);
        send(FUNC_READ, 6'd63, 24'sd0);           // beyond the lanes in use
        send(FUNC_LOAD_REF, 6'd63, 24'sh12_3456); // out of range, ignored
        send(3'd5, 6'd1, 24'sd0);
        send(3'd6, 6'd2, 24'sd0);
        send(3'd7, 6'd3, 24'sd0);
        drain();
        cfg_write(CFG_PRIOR_COUNT, 16'hFFFF);
        send(FUNC_LOAD_PRIOR, 6'd0, 24'sh7F_FFFF);
        send(FUNC_LOAD_PRIOR, 6'd1, 24'sh80_0000);
        send(FUNC_READ, 6'd0, 24'sd0);
        send(FUNC_READ, 6'd1, 24'sd0);
        send(FUNC_CLEAR, 6'd0, 24'sd0);
        send(FUNC_READ, 6'd0, 24'sd0);
        drain();
    endtask

    task automatic reconfigure();
        int pick;
        pick = $urandom_range(99);
        if (pick < 6) cfg_write(CFG_VECTOR_LENGTH, 16'd0);
        else if (pick < 10) cfg_write(CFG_VECTOR_LENGTH, 16'd127);
        else if (pick < 15) cfg_write(CFG_VECTOR_LENGTH, 16'd64);
        else if (pick < 25) cfg_write(CFG_VECTOR_LENGTH, 16'($urandom_range(9, 40)));
        else cfg_write(CFG_VECTOR_LENGTH, 16'($urandom_range(1, 8)));
        case ($urandom_range(5))
            0: cfg_write(CFG_TOTAL_COUNT, 16'd0);
            1: cfg_write(CFG_TOTAL_COUNT, 16'hFFFF);
            2: cfg_write(CFG_TOTAL_COUNT, 16'd1);
            default: cfg_write(CFG_TOTAL_COUNT, 16'($urandom_range(1, 300)));
        endcase
        case ($urandom_range(3))
            0: cfg_write(CFG_PRIOR_COUNT, 16'd0);
            1: cfg_write(CFG_PRIOR_COUNT, 16'hFFFF);
            default: cfg_write(CFG_PRIOR_COUNT, 16'($urandom()));
        endcase
    endtask

    task automatic test_random(input int beats, input int s_pct, input int r_pct);
        int stop_at;
        int next_cfg;
        int pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = beats_sent + beats;
        next_cfg = beats_sent;
        while (beats_sent < stop_at) begin
            if (beats_sent >= next_cfg) begin
                drain();
                reconfigure();
                next_cfg = beats_sent + 120;
            end
            pick = $urandom_range(99);
            if (pick < 55) sample_vector($urandom_range(9) == 0);
            else if (pick < 72) send(FUNC_READ, 6'($urandom()), rand_value());
            else if (pick < 80) offer(FUNC_LOAD_REF, 6'($urandom()), rand_value());
            else if (pick < 85) offer(FUNC_LOAD_PRIOR, 6'($urandom()), rand_value());
            else if (pick < 87) send(FUNC_CLEAR, 6'($urandom()), rand_value());
            else if (pick < 91) send(3'($urandom_range(5, 7)), 6'($urandom()), rand_value());
            else offer(FUNC_SAMPLE, 6'($urandom_range(lane_count() - 1)), rand_value());
        end
        drain();
    endtask

    // receiver holds off while reads keep coming, so full must rise
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 600;
        for (int i = 0; i < 16; i++) send(FUNC_READ, 6'($urandom()), 24'sd0);
        drain();
    endtask

    initial begin
        err_count = 0;
        beats_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 0;
        len_reg = 7'd64;
        total_reg = 16'd1;
        prior_reg = 16'd0;
        sq_sum = 0;
        foreach (rank_mem[i]) begin
            rank_mem[i] = '0;
            ref_ok[i] = 1'b0;
            diff_ok[i] = 1'b0;
            ref_mem[i] = '0;
            diff_mem[i] = '0;
        end
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_func <= FUNC_READ;
        i_index <= '0;
        i_value <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_VECTOR_LENGTH;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(540, 37, 58);
        test_random(540, 58, 37);
        test_random(540, 0, 0);
        test_backpressure();

        push <= 1'b0;
        while (rank_expect.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
        if (err_count == 0 && rank_expect.size() == 0) begin
            $display("tb_spatial_rank_accumulator_top: done, clean");
        end else begin
            $display("tb_spatial_rank_accumulator_top: done, errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #(64'd20 * 64'd6_000_000);
        $display("tb_spatial_rank_accumulator_top: done, errors");
        $finish;
    end

endmodule

// ===== spatial_rank_accumulator_top.f =====
rtl/srank_pkg.sv
rtl/srank_ram.sv
rtl/srank_fifo.sv
rtl/srank_front.sv
rtl/srank_div.sv
rtl/srank_back.sv
rtl/spatial_rank_accumulator_top.sv
rtl/srank_checker.sv
tb/sv/tb_spatial_rank_accumulator_top.sv
